[src/bilinear_corner_gradient_core_macros.svh]
// assertion macros for the gradient core
`ifndef BILINEAR_CORNER_GRADIENT_CORE_MACROS_SVH
`define BILINEAR_CORNER_GRADIENT_CORE_MACROS_SVH
`ifndef SYNTH
`define BCG_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("bcg assertion failed");
`define BCG_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("bcg assertion failed");
`else
`define BCG_ASSERT_IMP(label, pre, post)
`define BCG_ASSERT_NXT(label, pre, post)
`endif
`endif

[src/bcg_pkg.sv]
`timescale 1ns / 1ps
package bcg_pkg;
  localparam int BCG_CH         = 4;
  localparam int BCG_HLANES     = 8;
  localparam int BCG_DIV_STAGES = 8;
  localparam int BCG_MAX_DIM    = 16384;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_TL     = 3'd2,
    REG_TR     = 3'd3,
    REG_BL     = 3'd4,
    REG_BR     = 3'd5
  } bcg_reg_e;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] lq;
  } bcg_div_t;

  // two quotient bits of restoring division, numerator bits shift out of lq
  function automatic bcg_div_t bcg_div_step(bcg_div_t s, logic [14:0] d);
    bcg_div_t    o;
    logic [15:0] r;
    logic        q1;
    logic        q0;
    r  = {s.rem[14:0], s.lq[15]};
    q1 = (r >= {1'b0, d});
    if (q1) begin
      r = r - {1'b0, d};
    end
    r  = {r[14:0], s.lq[14]};
    q0 = (r >= {1'b0, d});
    if (q0) begin
      r = r - {1'b0, d};
    end
    o.rem = r;
    o.lq  = {s.lq[13:0], q1, q0};
    return o;
  endfunction
endpackage

[src/bilinear_corner_gradient_core.sv]
`timescale 1ns / 1ps
// bilinear four-corner gradient core
// configuration: apb-style port, 64-bit data, register i at byte address 8*i:
//   0 width, 1 height (15 bits each), 2..5 corner colors tl, tr, bl, br.
//   write only while no item is in flight. zero dimensions act as 1, larger
//   than MAX_DIMENSION act as MAX_DIMENSION. pready is always high.
// input: an item (pixel_x_i, pixel_y_i) is taken at a rising edge with
//   start_i high and busy_o low. busy_o stays low, one item per cycle.
// output: done_o marks pixel_color_o for one cycle, as the item leaves the
//   output register. throughput is one item per cycle.
// the path is a pipeline: clamp, multiply, add, eight radix-4 division
//   stages for the horizontal blend, then multiply, add and eight division
//   stages for the vertical blend, then the output register. each division
//   stage settles two quotient bits against the image width or height.
// reset empties the pipeline and restores width 1, height 1, black corners.
// the receiver cannot stall; results leave on their strobe cycle.
`include "bilinear_corner_gradient_core_macros.svh"
module bilinear_corner_gradient_core import bcg_pkg::*; #(
  parameter int MAX_DIMENSION = BCG_MAX_DIM
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [13:0] pixel_x_i,
  input  logic [13:0] pixel_y_i,
  output logic        done_o,
  output logic [63:0] pixel_color_o
);
  localparam logic [14:0] MaxDim = 15'(MAX_DIMENSION);
  localparam int          Latency = 2 * BCG_DIV_STAGES + 6;

  logic [14:0] width_q, height_q, w_eff_q, h_eff_q;
  logic [63:0] tl_q, tr_q, bl_q, br_q;
  logic        wr_en;
  bcg_reg_e    wr_idx;

  function automatic logic [14:0] eff_dim(logic [14:0] v);
    logic [14:0] r;
    r = v;
    if (v == 15'd0) begin
      r = 15'd1;
    end else if (v > MaxDim) begin
      r = MaxDim;
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = bcg_reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 15'd1;
      height_q <= 15'd1;
      w_eff_q  <= 15'd1;
      h_eff_q  <= 15'd1;
      tl_q     <= '0;
      tr_q     <= '0;
      bl_q     <= '0;
      br_q     <= '0;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_WIDTH: begin
          width_q <= pwdata[14:0];
          w_eff_q <= eff_dim(pwdata[14:0]);
        end
        REG_HEIGHT: begin
          height_q <= pwdata[14:0];
          h_eff_q  <= eff_dim(pwdata[14:0]);
        end
        REG_TL:  tl_q <= pwdata;
        REG_TR:  tr_q <= pwdata;
        REG_BL:  bl_q <= pwdata;
        REG_BR:  br_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_WIDTH:  prdata = {49'd0, width_q};
      REG_HEIGHT: prdata = {49'd0, height_q};
      REG_TL:     prdata = tl_q;
      REG_TR:     prdata = tr_q;
      REG_BL:     prdata = bl_q;
      REG_BR:     prdata = br_q;
      default:    prdata = '0;
    endcase
  end

  // stage a: clamp coordinates, form weights
  logic        in_fire;
  logic [14:0] x_cl, y_cl;
  logic        va_q;
  logic [14:0] xa_q, xna_q, ya_q, yna_q;

  assign in_fire = start_i && !busy_o;
  assign x_cl = ({1'b0, pixel_x_i} > w_eff_q) ? w_eff_q : {1'b0, pixel_x_i};
  assign y_cl = ({1'b0, pixel_y_i} > h_eff_q) ? h_eff_q : {1'b0, pixel_y_i};

  // stage b: horizontal products, lanes 0..3 top channels, 4..7 bottom
  logic        vb_q;
  logic [30:0] pl_q [BCG_HLANES];
  logic [30:0] pr_q [BCG_HLANES];
  logic [14:0] yb_q, ynb_q;

  // stage c and horizontal division stages
  logic        hv_q  [BCG_DIV_STAGES+1];
  bcg_div_t    hd_q  [BCG_DIV_STAGES+1][BCG_HLANES];
  logic [14:0] yh_q  [BCG_DIV_STAGES+1];
  logic [14:0] ynh_q [BCG_DIV_STAGES+1];

  // stage d: vertical products
  logic        vd_q;
  logic [30:0] pt_q [BCG_CH];
  logic [30:0] pb_q [BCG_CH];

  // stage e and vertical division stages
  logic        vv_q [BCG_DIV_STAGES+1];
  bcg_div_t    vd_div_q [BCG_DIV_STAGES+1][BCG_CH];

  logic        out_v_q;
  logic [63:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vd_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k <= BCG_DIV_STAGES; k++) begin
        hv_q[k] <= 1'b0;
        vv_q[k] <= 1'b0;
      end
    end else begin
      va_q    <= in_fire;
      vb_q    <= va_q;
      hv_q[0] <= vb_q;
      vd_q    <= hv_q[BCG_DIV_STAGES];
      vv_q[0] <= vd_q;
      out_v_q <= vv_q[BCG_DIV_STAGES];
      for (int k = 1; k <= BCG_DIV_STAGES; k++) begin
        hv_q[k] <= hv_q[k-1];
        vv_q[k] <= vv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q  <= x_cl;
    xna_q <= w_eff_q - x_cl;
    ya_q  <= y_cl;
    yna_q <= h_eff_q - y_cl;

    yb_q  <= ya_q;
    ynb_q <= yna_q;
    for (int c = 0; c < BCG_CH; c++) begin
      pl_q[c]        <= 31'(tl_q[16*c +: 16]) * 31'(xna_q);
      pr_q[c]        <= 31'(tr_q[16*c +: 16]) * 31'(xa_q);
      pl_q[c+BCG_CH] <= 31'(bl_q[16*c +: 16]) * 31'(xna_q);
      pr_q[c+BCG_CH] <= 31'(br_q[16*c +: 16]) * 31'(xa_q);
    end

    yh_q[0]  <= yb_q;
    ynh_q[0] <= ynb_q;
    for (int l = 0; l < BCG_HLANES; l++) begin
      hd_q[0][l] <= bcg_div_t'({1'b0, pl_q[l]} + {1'b0, pr_q[l]});
    end
    for (int k = 1; k <= BCG_DIV_STAGES; k++) begin
      yh_q[k]  <= yh_q[k-1];
      ynh_q[k] <= ynh_q[k-1];
      for (int l = 0; l < BCG_HLANES; l++) begin
        hd_q[k][l] <= bcg_div_step(hd_q[k-1][l], w_eff_q);
      end
    end

    for (int c = 0; c < BCG_CH; c++) begin
      pt_q[c] <= 31'(hd_q[BCG_DIV_STAGES][c].lq) * 31'(ynh_q[BCG_DIV_STAGES]);
      pb_q[c] <= 31'(hd_q[BCG_DIV_STAGES][c+BCG_CH].lq) * 31'(yh_q[BCG_DIV_STAGES]);
      vd_div_q[0][c] <= bcg_div_t'({1'b0, pt_q[c]} + {1'b0, pb_q[c]});
    end
    for (int k = 1; k <= BCG_DIV_STAGES; k++) begin
      for (int c = 0; c < BCG_CH; c++) begin
        vd_div_q[k][c] <= bcg_div_step(vd_div_q[k-1][c], h_eff_q);
      end
    end

    for (int c = 0; c < BCG_CH; c++) begin
      out_q[16*c +: 16] <= vd_div_q[BCG_DIV_STAGES][c].lq;
    end
  end

  assign done_o        = out_v_q;
  assign pixel_color_o = out_q;

  `BCG_ASSERT_IMP(a_latency, in_fire, ##Latency done_o)
  `BCG_ASSERT_IMP(a_no_orphan, done_o, $past(in_fire, Latency))
  `BCG_ASSERT_IMP(a_x_clamped, va_q, xa_q <= w_eff_q)
  `BCG_ASSERT_IMP(a_hrem_bound, hv_q[1], hd_q[1][0].rem < {1'b0, w_eff_q})
  `BCG_ASSERT_IMP(a_vrem_bound, vv_q[1], vd_div_q[1][0].rem < {1'b0, h_eff_q})
endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import bcg_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;

  class gradient_scoreboard;
    logic [14:0] width_q;
    logic [14:0] height_q;
    logic [63:0] corner_q [4];
    logic [63:0] pending_colors [$];
    int          fail_count;

    function new();
      width_q = 15'd1;
      height_q = 15'd1;
      foreach (corner_q[k]) corner_q[k] = '0;
      fail_count = 0;
    endfunction

    function void write_reg(bcg_reg_e idx, logic [63:0] val);
      case (idx)
        REG_WIDTH:  width_q = val[14:0];
        REG_HEIGHT: height_q = val[14:0];
        REG_TL:     corner_q[0] = val;
        REG_TR:     corner_q[1] = val;
        REG_BL:     corner_q[2] = val;
        REG_BR:     corner_q[3] = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] blend_color(logic [13:0] px, logic [13:0] py);
      longint unsigned w, h, x, y, tl, tr, bl, br, top_v, bot_v, v;
      logic [63:0] res;
      w = (width_q == 0) ? 1 : (width_q > BCG_MAX_DIM) ? BCG_MAX_DIM : width_q;
      h = (height_q == 0) ? 1 : (height_q > BCG_MAX_DIM) ? BCG_MAX_DIM : height_q;
      x = (px > w) ? w : px;
      y = (py > h) ? h : py;
      res = '0;
      for (int ch = 0; ch < 4; ch++) begin
        tl = corner_q[0][ch*16 +: 16];
        tr = corner_q[1][ch*16 +: 16];
        bl = corner_q[2][ch*16 +: 16];
        br = corner_q[3][ch*16 +: 16];
        top_v = ((tl * (w - x) + tr * x) / w) & 16'hFFFF;
        bot_v = ((bl * (w - x) + br * x) / w) & 16'hFFFF;
        v = ((top_v * (h - y) + bot_v * y) / h) & 16'hFFFF;
        res[ch*16 +: 16] = v[15:0];
      end
      return res;
    endfunction

    function void note_pixel(logic [13:0] px, logic [13:0] py);
      pending_colors.push_back(blend_color(px, py));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      fail_count++;
    endtask

    task check_color(logic [63:0] got);
      logic [63:0] want;
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %h", got));
      end else begin
        want = pending_colors.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("pixel_color %h, want %h", got, want));
        end
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [13:0] pixel_x_i = '0;
  logic [13:0] pixel_y_i = '0;
  logic        done_o;
  logic [63:0] pixel_color_o;

  gradient_scoreboard sb = new();
  int idle_pct = 0;
  int stall_cycles = 0;

  bilinear_corner_gradient_core u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_color(pixel_color_o);
      if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("bilinear_corner_gradient_core test failed");
        $finish;
      end
    end
  end

  task write_reg(bcg_reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 6'(idx) << 3;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task send_pixel(logic [13:0] px, logic [13:0] py);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    do @(posedge clk_i); while (busy_o);
    sb.note_pixel(px, py);
  endtask

  task drain;
    start_i <= 1'b0;
    while (sb.pending_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task setup_image(logic [14:0] w, logic [14:0] h);
    write_reg(REG_WIDTH, 64'(w) | ({$urandom, $urandom} & ~64'h7FFF));
    write_reg(REG_HEIGHT, 64'(h));
    write_reg(REG_TL, {$urandom, $urandom});
    write_reg(REG_TR, {$urandom, $urandom});
    write_reg(REG_BL, {$urandom, $urandom});
    write_reg(REG_BR, {$urandom, $urandom});
  endtask

  function logic [14:0] pick_dim();
    case ($urandom_range(5, 0))
      0: return 15'($urandom_range(2, 1));
      1: return 15'(BCG_MAX_DIM);
      2: return 15'($urandom);
      default: return 15'($urandom_range(300, 1));
    endcase
  endfunction

  function logic [13:0] pick_coord(logic [14:0] dim);
    if ($urandom_range(9, 0) == 0) return 14'($urandom);
    if (dim == 0) return '0;
    return 14'($urandom_range(((dim > BCG_MAX_DIM) ? BCG_MAX_DIM : dim) - 1, 0));
  endfunction

  initial begin
    logic [14:0] w, h;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_pixel(14'd0, 14'd0);
    drain();
    write_reg(REG_WIDTH, 64'd16384);
    write_reg(REG_HEIGHT, 64'd16384);
    write_reg(REG_TL, '0);
    write_reg(REG_TR, '1);
    write_reg(REG_BL, '1);
    write_reg(REG_BR, 64'h0123_4567_89AB_CDEF);
    send_pixel(14'd0, 14'd0);
    send_pixel(14'h3FFF, 14'h3FFF);
    send_pixel(14'h2AAA, 14'h1555);
    send_pixel(14'h1555, 14'h2AAA);
    drain();
    write_reg(REG_WIDTH, 64'd0);
    write_reg(REG_HEIGHT, 64'h7FFF);
    send_pixel(14'd0, 14'd5);
    send_pixel(14'd3, 14'h3FFF);
    drain();
    write_reg(REG_WIDTH, 64'd7);
    write_reg(REG_HEIGHT, 64'd0);
    send_pixel(14'd6, 14'd0);
    send_pixel(14'd7, 14'd0);
    send_pixel(14'd100, 14'd2);
    send_pixel(14'd3, 14'd1);
    drain();

    for (int ph = 0; ph < 24; ph++) begin
      idle_pct = (ph < 8) ? 26 : (ph < 16) ? 59 : 0;
      w = pick_dim();
      h = pick_dim();
      setup_image(w, h);
      repeat (33) send_pixel(pick_coord(w), pick_coord(h));
      drain();
    end

    if (sb.fail_count == 0) begin
      $display("bilinear_corner_gradient_core test passed");
    end else begin
      $display("bilinear_corner_gradient_core test failed");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/bcg_pkg.sv
src/bilinear_corner_gradient_core.sv
dv/tb_top.sv
